// File: rtl/core/sfu_pkg.sv
`default_nettype none

package sfu_pkg;

  // Field widths fixed by the result format
  localparam int unsigned ADDR_W      = 13;
  localparam int unsigned WORD_W      = 15;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SEQ_W       = 7;
  localparam int unsigned BOOT_W      = 56;
  localparam int unsigned BOOT_WORD_W = 14;
  localparam int unsigned BOOT_WORDS  = BOOT_W / BOOT_WORD_W;

  // Frame layout: marker, three id bytes, sequence, data..., end marker
  localparam int unsigned HDR_BYTES = 5;
  localparam logic [BYTE_W-1:0] SOF_BYTE = 8'hF0;
  localparam logic [BYTE_W-1:0] EOF_BYTE = 8'hF7;
  localparam logic [BYTE_W-1:0] ID0_BYTE = 8'h00;
  localparam logic [BYTE_W-1:0] ID1_BYTE = 8'h7F;
  localparam logic [BYTE_W-1:0] ID2_BYTE = 8'h12;

  localparam logic [SEQ_W-1:0]  SEQ_LAST     = 7'd127;
  localparam logic [ADDR_W-1:0] PROT_BASE_RST = 13'h1E20;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_FRAME     = 2'd0,
    ERR_SEQUENCE  = 2'd1,
    ERR_PROTECTED = 2'd2
  } err_e;

  typedef enum logic {
    CFG_BOOT_VECTOR    = 1'b0,
    CFG_PROTECTED_BASE = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_RX,
    ST_CHECK,
    ST_READ,
    ST_EMIT,
    ST_HALT
  } state_e;

endpackage

`default_nettype wire

// File: rtl/core/sysex_firmware_frame_unpacker.sv
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        sink       in_valid_i/in_stall_o   rx_byte_i
// out       source     out_valid_o/out_stall_i kind_o, error_code_o, write_address_o,
//                                              write_word_o, last_o
// cfg       sink       cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// Bytes are taken one per cycle while a frame is received; each data byte goes
// into a two-bank byte memory (even/odd bytes of a word).
// After the end marker: a check state, then for each flash word a bank read and an
// output load; ROW_WORDS words for a normal row, plus the saved vector words for row
// zero. The check and each load wait while out_stall_i holds the output register.
// Input is stalled from the end marker until the last result is in the output register.
// After reset the block takes its first byte as a frame's start marker; on completion
// or any error it drops every further byte until reset.

module sysex_firmware_frame_unpacker
  import sfu_pkg::*;
#(
  parameter int unsigned ROW_WORDS    = 32,
  parameter int unsigned VECTOR_WORDS = 4
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  // configuration
  input  wire                     cfg_we_i,
  input  wire                     cfg_idx_i,
  input  wire  [BOOT_W-1:0]       cfg_wdata_i,
  // received bytes
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire  [BYTE_W-1:0]       rx_byte_i,
  // results
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output logic [1:0]              kind_o,
  output logic [1:0]              error_code_o,
  output logic [ADDR_W-1:0]       write_address_o,
  output logic [WORD_W-1:0]       write_word_o,
  output logic                    last_o
);

  localparam int unsigned DATA_BYTES  = 2 * ROW_WORDS;
  localparam int unsigned FRAME_BYTES = DATA_BYTES + HDR_BYTES + 1;
  localparam int unsigned PW          = $clog2(FRAME_BYTES);
  localparam int unsigned KW          = $clog2(ROW_WORDS);
  localparam int unsigned NVEC        = (VECTOR_WORDS < ROW_WORDS) ? VECTOR_WORDS : ROW_WORDS;

  // Control and configuration state
  state_e              state_q, state_d;
  logic [PW-1:0]       pos_q;
  logic                hdr_ok_q;
  logic [BYTE_W-1:0]   seq_q;
  logic [SEQ_W-1:0]    exp_q;
  logic [ADDR_W-1:0]   row_q;
  logic [KW-1:0]       k_q;
  logic                phase_q;   // 0: row words, 1: saved original vector words
  logic [BOOT_W-1:0]   boot_q;
  logic [ADDR_W-1:0]   base_q;

  // Output register
  logic                out_valid_q;
  kind_e               kind_q;
  err_e                err_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [WORD_W-1:0]   word_q;
  logic                last_q;

  // Byte memories, one per byte of a word
  logic [BYTE_W-1:0]   mem_even [ROW_WORDS];
  logic [BYTE_W-1:0]   mem_odd  [ROW_WORDS];
  logic [BYTE_W-1:0]   even_rd_q, odd_rd_q;

  logic                in_acc;
  logic                out_free;
  logic                pos_last;
  logic [PW-1:0]       data_idx;
  logic                mem_we;
  logic                rd_en;
  logic                out_load;
  kind_e               ld_kind;
  err_e                ld_err;
  logic [ADDR_W-1:0]   ld_addr;
  logic [WORD_W-1:0]   ld_word;
  logic                ld_last;
  logic                chk_fail;
  logic                seq_match;
  logic                prot_hit;
  logic                emit_last;
  logic                emit_to_saved;
  logic                use_boot;
  logic [BOOT_WORD_W-1:0] boot_word [BOOT_WORDS];
  logic [BOOT_WORD_W-1:0] boot_sel;
  logic [WORD_W-1:0]   row_word;
  logic [ADDR_W-1:0]   k_ext;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign pos_last = (pos_q == PW'(FRAME_BYTES - 1));
  assign data_idx = pos_q - PW'(HDR_BYTES);
  assign k_ext    = {{(ADDR_W - KW){1'b0}}, k_q};

  // Frame checks, valid in the check state
  assign seq_match = (seq_q == {1'b0, exp_q});
  assign prot_hit  = (row_q != '0) && (row_q >= base_q);
  assign chk_fail  = !hdr_ok_q || (seq_q == '0) || !seq_match || prot_hit;

  // Emission bookkeeping
  assign emit_to_saved = !phase_q && (k_q == KW'(ROW_WORDS - 1)) && (row_q == '0);
  assign emit_last     = phase_q ? (k_q == KW'(NVEC - 1))
                                 : ((k_q == KW'(ROW_WORDS - 1)) && (row_q != '0));

  // Boot vector words and the assembled word
  for (genvar i = 0; i < BOOT_WORDS; i++) begin : g_boot
    assign boot_word[i] = boot_q[i*BOOT_WORD_W +: BOOT_WORD_W];
  end
  assign boot_sel = ({1'b0, k_q} < (KW+1)'(BOOT_WORDS)) ? boot_word[k_q[1:0]] : '0;
  assign use_boot = (row_q == '0) && !phase_q && ({1'b0, k_q} < (KW+1)'(NVEC));
  assign row_word = ({even_rd_q, 7'b0}) | {7'b0, odd_rd_q};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RX: begin
        if (in_acc && pos_last) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (out_free) begin
          state_d = chk_fail ? ST_HALT : ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = emit_last ? ST_RX : ST_READ;
        end
      end
      ST_HALT: begin
        state_d = ST_HALT;
      end
      default: begin
        state_d = ST_HALT;
      end
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    in_stall_o = 1'b1;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    ld_kind    = KIND_WRITE;
    ld_err     = ERR_FRAME;
    ld_addr    = '0;
    ld_word    = '0;
    ld_last    = 1'b1;
    unique case (state_q)
      ST_RX: begin
        in_stall_o = 1'b0;
        mem_we     = in_acc && (pos_q >= PW'(HDR_BYTES)) && !pos_last;
      end
      ST_CHECK: begin
        out_load = out_free && chk_fail;
        priority if (!hdr_ok_q) begin
          ld_kind = KIND_ERROR;
          ld_err  = ERR_FRAME;
        end else if (seq_q == '0) begin
          ld_kind = KIND_DONE;
        end else if (!seq_match) begin
          ld_kind = KIND_ERROR;
          ld_err  = ERR_SEQUENCE;
        end else begin
          ld_kind = KIND_ERROR;
          ld_err  = ERR_PROTECTED;
        end
      end
      ST_READ: begin
        rd_en = 1'b1;
      end
      ST_EMIT: begin
        out_load = out_free;
        ld_kind  = KIND_WRITE;
        ld_last  = emit_last;
        if (phase_q) begin
          ld_addr = base_q + ADDR_W'(1) + k_ext;
          ld_word = row_word;
        end else begin
          ld_addr = row_q + k_ext;
          ld_word = use_boot ? {1'b0, boot_sel} : row_word;
        end
      end
      ST_HALT: begin
        in_stall_o = 1'b0;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_RX;
      pos_q    <= '0;
      hdr_ok_q <= 1'b1;
      seq_q    <= '0;
      exp_q    <= SEQ_W'(1);
      row_q    <= '0;
      k_q      <= '0;
      phase_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // byte reception
      if (state_q == ST_RX && in_acc) begin
        priority if (pos_q == PW'(0)) begin
          hdr_ok_q <= (rx_byte_i == SOF_BYTE);
        end else if (pos_q == PW'(1)) begin
          hdr_ok_q <= hdr_ok_q && (rx_byte_i == ID0_BYTE);
        end else if (pos_q == PW'(2)) begin
          hdr_ok_q <= hdr_ok_q && (rx_byte_i == ID1_BYTE);
        end else if (pos_q == PW'(3)) begin
          hdr_ok_q <= hdr_ok_q && (rx_byte_i == ID2_BYTE);
        end else if (pos_q == PW'(4)) begin
          seq_q <= rx_byte_i;
        end else if (pos_last) begin
          hdr_ok_q <= hdr_ok_q && (rx_byte_i == EOF_BYTE);
        end
        pos_q <= pos_last ? '0 : pos_q + PW'(1);
      end
      // frame check: the expected sequence moves on a match even if the row is protected
      if (state_q == ST_CHECK && out_free) begin
        if (hdr_ok_q && (seq_q != '0) && seq_match) begin
          exp_q <= (exp_q >= SEQ_LAST) ? SEQ_W'(1) : exp_q + SEQ_W'(1);
        end
        hdr_ok_q <= 1'b1;
        k_q      <= '0;
        phase_q  <= 1'b0;
      end
      // word emission
      if (state_q == ST_EMIT && out_free) begin
        if (emit_last) begin
          row_q   <= row_q + ADDR_W'(ROW_WORDS);
          k_q     <= '0;
          phase_q <= 1'b0;
        end else if (emit_to_saved) begin
          k_q     <= '0;
          phase_q <= 1'b1;
        end else begin
          k_q <= k_q + KW'(1);
        end
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_q <= '0;
      base_q <= PROT_BASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BOOT_VECTOR:    boot_q <= cfg_wdata_i;
        CFG_PROTECTED_BASE: base_q <= cfg_wdata_i[ADDR_W-1:0];
        default:            boot_q <= boot_q;
      endcase
    end
  end

  // Byte memories: writes only while receiving, reads only while emitting,
  // so the same entry is never written and read in one cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      if (data_idx[0]) begin
        mem_odd[data_idx[KW:1]] <= rx_byte_i;
      end else begin
        mem_even[data_idx[KW:1]] <= rx_byte_i;
      end
    end
    if (rd_en) begin
      even_rd_q <= mem_even[k_q];
      odd_rd_q  <= mem_odd[k_q];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q <= ld_kind;
      err_q  <= ld_err;
      addr_q <= ld_addr;
      word_q <= ld_word;
      last_q <= ld_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign error_code_o    = err_q;
  assign write_address_o = addr_q;
  assign write_word_o    = word_q;
  assign last_o          = last_q;

  // Checks
  a_halt_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_HALT) ##1 (state_q == ST_HALT) |-> out_valid_q && last_q)
    else $error("halt entered without a final result");

  a_exp_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_q != '0)
    else $error("expected sequence is zero");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < PW'(FRAME_BYTES))
    else $error("frame position out of range");

  a_saved_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && phase_q |-> ({1'b0, k_q} < (KW+1)'(NVEC)) && (row_q == '0))
    else $error("saved vector index out of range");

  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q != $past(row_q)) |-> (row_q == $past(row_q) + ADDR_W'(ROW_WORDS)))
    else $error("row address moved by other than one row");

endmodule

`default_nettype wire

// File: test/sysex_firmware_frame_unpacker_tb.sv
`default_nettype none

module sysex_firmware_frame_unpacker_tb;
  import sfu_pkg::*;

  localparam int unsigned ROW_WORDS    = 32;
  localparam int unsigned VECTOR_WORDS = 4;
  localparam int unsigned DATA_BYTES   = 2 * ROW_WORDS;
  localparam int unsigned FRAME_BYTES  = DATA_BYTES + 6;
  localparam int unsigned NVEC = (VECTOR_WORDS < ROW_WORDS) ? VECTOR_WORDS : ROW_WORDS;
  localparam int unsigned CYCLE_LIMIT  = 20_000;
  localparam int unsigned HOLD_CYCLES  = 400;
  // bytes of a new frame offered once the block has halted
  localparam int unsigned TRAIL_BYTES  = 4;
  // idle mix changes at these byte counts
  localparam int unsigned PHASE2_BYTES = FRAME_BYTES + 2;
  localparam int unsigned PHASE3_BYTES = FRAME_BYTES + 36;
  // longest burst (row zero) plus margin
  localparam int unsigned SETTLE_CYCLES = 2 * (ROW_WORDS + VECTOR_WORDS) + 16;

  typedef struct packed {
    kind_e             kind;
    err_e              code;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
    logic              last;
  } flash_result_t;

  // One directed frame: data fill pattern and an optional typed first result
  typedef struct {
    logic [BYTE_W-1:0] even_byte;
    logic [BYTE_W-1:0] odd_byte;
    bit                random_data;
    bit                typed;
    flash_result_t     first;
  } frame_row_t;

  // Typed first result of a queued frame, if any
  typedef struct {
    bit            typed;
    flash_result_t first;
  } frame_check_t;

  typedef enum int {
    END_DONE,
    END_BAD_FRAME,
    END_BAD_SEQ,
    END_PROTECTED
  } finale_e;

  // DUT signals
  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [BOOT_W-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [BYTE_W-1:0] rx_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [1:0]        kind_o;
  logic [1:0]        error_code_o;
  logic [ADDR_W-1:0] write_address_o;
  logic [WORD_W-1:0] write_word_o;
  logic              last_o;

  // Predictor state and register copies
  logic [BOOT_W-1:0] boot_vec_q;
  logic [ADDR_W-1:0] prot_base_q;
  int unsigned       rx_pos;
  bit                hdr_good;
  logic [BYTE_W-1:0] rx_seq;
  logic [BYTE_W-1:0] row_bytes [DATA_BYTES];
  logic [SEQ_W-1:0]  seq_expected;
  logic [ADDR_W-1:0] row_addr;
  bit                is_halted;

  flash_result_t     results_due [$];
  frame_check_t      frame_checks [$];

  // Stimulus bookkeeping
  logic [BYTE_W-1:0] tx_bytes [$];
  logic [SEQ_W-1:0]  tx_seq = 1;
  int                tx_idle_pct = 17;
  int                rx_idle_pct = 59;
  bit                hold_req = 1'b0;
  int                fail_count = 0;
  int                results_seen = 0;
  int                bytes_taken = 0;
  int                frames_sent = 0;

  // Directed frames, each sent with the next expected sequence number
  frame_row_t dir_rows [1] = '{
    // row zero, all-ones data under an all-ones boot vector
    '{8'hFF, 8'hFF, 1'b0, 1'b1, '{KIND_WRITE, ERR_FRAME, 13'd0, 15'h3FFF, 1'b0}}
  };

  always #4 clk_i = ~clk_i;

  sysex_firmware_frame_unpacker #(
    .ROW_WORDS   (ROW_WORDS),
    .VECTOR_WORDS(VECTOR_WORDS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .error_code_o   (error_code_o),
    .write_address_o(write_address_o),
    .write_word_o   (write_word_o),
    .last_o         (last_o)
  );

  function automatic flash_result_t make_result(kind_e k, err_e e, logic [ADDR_W-1:0] a,
                                                logic [WORD_W-1:0] w, logic l);
    flash_result_t r;
    r.kind = k;
    r.code = e;
    r.addr = a;
    r.word = w;
    r.last = l;
    return r;
  endfunction

  // End of frame: run the checks in order, then emit the row writes
  function automatic void close_frame();
    logic [WORD_W-1:0] saved [NVEC];
    logic [WORD_W-1:0] w;
    is_halted = 1'b1;
    if (!hdr_good) begin
      results_due.push_back(make_result(KIND_ERROR, ERR_FRAME, '0, '0, 1'b1));
      return;
    end
    if (rx_seq == '0) begin
      results_due.push_back(make_result(KIND_DONE, ERR_FRAME, '0, '0, 1'b1));
      return;
    end
    if (rx_seq != {1'b0, seq_expected}) begin
      results_due.push_back(make_result(KIND_ERROR, ERR_SEQUENCE, '0, '0, 1'b1));
      return;
    end
    seq_expected = (seq_expected >= SEQ_LAST) ? SEQ_W'(1) : seq_expected + 1'b1;
    if (row_addr != '0 && row_addr >= prot_base_q) begin
      results_due.push_back(make_result(KIND_ERROR, ERR_PROTECTED, '0, '0, 1'b1));
      return;
    end
    is_halted = 1'b0;

    for (int k = 0; k < ROW_WORDS; k++) begin
      w = {row_bytes[2*k], 7'd0} | {7'd0, row_bytes[2*k+1]};
      // row zero: boot vector replaces the first words
      if (row_addr == '0 && k < NVEC) begin
        saved[k] = w;
        w = (k * BOOT_WORD_W >= BOOT_W) ? '0 :
            WORD_W'((boot_vec_q >> (k * BOOT_WORD_W)) & 56'h3FFF);
      end
      results_due.push_back(make_result(KIND_WRITE, ERR_FRAME, ADDR_W'(row_addr + k), w, 1'b0));
    end
    if (row_addr == '0) begin
      for (int k = 0; k < NVEC; k++)
        results_due.push_back(make_result(KIND_WRITE, ERR_FRAME,
                                          ADDR_W'(prot_base_q + 1 + k), saved[k], 1'b0));
    end
    results_due[results_due.size()-1].last = 1'b1;
    row_addr = ADDR_W'(row_addr + ROW_WORDS);
  endfunction

  // Predictor: one accepted byte
  function automatic void unpack_byte(logic [BYTE_W-1:0] b);
    int base;
    if (is_halted) return;
    if (rx_pos == 0) hdr_good = (b == SOF_BYTE);
    else if (rx_pos == 1) hdr_good = hdr_good && (b == ID0_BYTE);
    else if (rx_pos == 2) hdr_good = hdr_good && (b == ID1_BYTE);
    else if (rx_pos == 3) hdr_good = hdr_good && (b == ID2_BYTE);
    else if (rx_pos == 4) rx_seq = b;
    else if (rx_pos < FRAME_BYTES - 1) row_bytes[rx_pos-HDR_BYTES] = b;

    if (rx_pos + 1 < FRAME_BYTES) begin
      rx_pos++;
      return;
    end
    hdr_good = hdr_good && (b == EOF_BYTE);
    rx_pos = 0;
    base = results_due.size();
    close_frame();
    hdr_good = 1'b1;
    // hand-typed first result overrides the computed one
    if (frame_checks.size() != 0) begin
      if (frame_checks[0].typed) results_due[base] = frame_checks[0].first;
      void'(frame_checks.pop_front());
    end
  endfunction

  function automatic void cmp_field(string name, logic [WORD_W-1:0] want_v,
                                    logic [WORD_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want_v, got_v);
      fail_count++;
    end
  endfunction

  task automatic check_result();
    flash_result_t want;
    if (results_due.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual kind %0d addr %0h word %0h",
               $time, kind_o, write_address_o, write_word_o);
      fail_count++;
      return;
    end
    want = results_due.pop_front();
    results_seen++;
    cmp_field("kind", want.kind, kind_o);
    cmp_field("error_code", want.code, error_code_o);
    cmp_field("write_address", want.addr, write_address_o);
    cmp_field("write_word", want.word, write_word_o);
    cmp_field("last", want.last, last_o);
  endtask

  // Build one frame and append it to the byte backlog
  task automatic queue_frame(input logic [BYTE_W-1:0] seq, input int bad_pos,
                             input logic [BYTE_W-1:0] even_b, input logic [BYTE_W-1:0] odd_b,
                             input bit rnd, input bit typed, input flash_result_t first);
    logic [BYTE_W-1:0] fb [FRAME_BYTES];
    frame_check_t      fc;
    fb[0] = SOF_BYTE;
    fb[1] = ID0_BYTE;
    fb[2] = ID1_BYTE;
    fb[3] = ID2_BYTE;
    fb[4] = seq;
    for (int i = 0; i < DATA_BYTES; i++)
      fb[HDR_BYTES+i] = rnd ? BYTE_W'($urandom) : ((i % 2) ? odd_b : even_b);
    fb[FRAME_BYTES-1] = EOF_BYTE;
    if (bad_pos >= 0) fb[bad_pos] = fb[bad_pos] ^ BYTE_W'($urandom_range(1, 255));
    // keep about one frame queued so the sender never runs dry
    while (tx_bytes.size() > FRAME_BYTES) @(posedge clk_i);
    fc.typed = typed;
    fc.first = first;
    frame_checks.push_back(fc);
    foreach (fb[i]) tx_bytes.push_back(fb[i]);
    frames_sent++;
  endtask

  task automatic send_row(input logic [BYTE_W-1:0] even_b, input logic [BYTE_W-1:0] odd_b,
                          input bit rnd, input bit typed, input flash_result_t first);
    queue_frame({1'b0, tx_seq}, -1, even_b, odd_b, rnd, typed, first);
    tx_seq = (tx_seq >= SEQ_LAST) ? SEQ_W'(1) : tx_seq + 1'b1;
  endtask

  // Wait until every byte is taken and every result has come back
  task automatic drain();
    while (tx_bytes.size() != 0 || in_valid_i) @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [BOOT_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_BOOT_VECTOR) boot_vec_q = val;
    else prot_base_q = val[ADDR_W-1:0];
  endtask

  // Byte sender: one transaction per accepted byte
  initial begin : byte_sender
    in_valid_i <= 1'b0;
    rx_byte_i  <= '0;
    forever begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) begin
        unpack_byte(rx_byte_i);
        void'(tx_bytes.pop_front());
        bytes_taken++;
        // first frame complete: hold the results off while the next frame waits
        if (bytes_taken == FRAME_BYTES) hold_req = 1'b1;
        // idle mix moves on as the run proceeds
        if (bytes_taken == PHASE2_BYTES) begin
          tx_idle_pct = 59;
          rx_idle_pct = 17;
        end
        if (bytes_taken == PHASE3_BYTES) begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      end
      // a stalled byte stays put
      if (!(in_valid_i && in_stall_o)) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= tx_bytes[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result sink with random stalls and one long hold-off
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) check_result();
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    finale_e           finale;
    int                bad_pos;
    int                seq_v;
    int                pick;
    logic [BYTE_W-1:0] end_seq;
    logic [ADDR_W-1:0] end_base;
    flash_result_t     end_first;

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_BOOT_VECTOR;
    cfg_wdata_i <= '0;
    boot_vec_q   = '0;
    prot_base_q  = PROT_BASE_RST;
    rx_pos       = 0;
    hdr_good     = 1'b1;
    rx_seq       = '0;
    seq_expected = 1;
    row_addr     = '0;
    is_halted    = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Closing frame chosen up front so the base is set before anything is in flight
    finale = finale_e'($urandom_range(0, 3));
    if (finale == END_PROTECTED) begin
      // row address is one row past zero when the closing frame ends
      end_base = ADDR_W'($urandom_range(0, ROW_WORDS));
    end else begin
      pick     = $urandom_range(0, 2);
      end_base = (pick == 0) ? PROT_BASE_RST : ((pick == 1) ? 13'h1FFF : 13'h0000);
    end
    write_reg(CFG_BOOT_VECTOR, '1);
    write_reg(CFG_PROTECTED_BASE, BOOT_W'(end_base));

    // Directed frames
    foreach (dir_rows[i]) begin
      send_row(dir_rows[i].even_byte, dir_rows[i].odd_byte, dir_rows[i].random_data,
               dir_rows[i].typed, dir_rows[i].first);
    end

    // Closing frame right behind: completion or one of the errors, chosen at random
    bad_pos = -1;
    end_seq = {1'b0, tx_seq};
    case (finale)
      END_DONE: begin
        end_seq   = '0;
        end_first = make_result(KIND_DONE, ERR_FRAME, '0, '0, 1'b1);
      end
      END_BAD_FRAME: begin
        // corrupt a marker or an id byte
        bad_pos = $urandom_range(0, 4);
        if (bad_pos == 4) bad_pos = FRAME_BYTES - 1;
        end_first = make_result(KIND_ERROR, ERR_FRAME, '0, '0, 1'b1);
      end
      END_BAD_SEQ: begin
        if ($urandom_range(1)) begin
          end_seq = BYTE_W'($urandom_range(128, 255));
        end else begin
          seq_v   = ((int'(tx_seq) - 1 + $urandom_range(1, 126)) % 127) + 1;
          end_seq = BYTE_W'(seq_v);
        end
        end_first = make_result(KIND_ERROR, ERR_SEQUENCE, '0, '0, 1'b1);
      end
      default: begin
        end_first = make_result(KIND_ERROR, ERR_PROTECTED, '0, '0, 1'b1);
      end
    endcase
    queue_frame(end_seq, bad_pos, 8'h00, 8'h00, 1'b1, 1'b1, end_first);
    drain();

    // the block is halted now; the start of a new frame must be dropped
    tx_bytes.push_back(SOF_BYTE);
    tx_bytes.push_back(ID0_BYTE);
    tx_bytes.push_back(ID1_BYTE);
    tx_bytes.push_back(ID2_BYTE);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d frames and %0d trailing bytes (%0d taken), checked %0d results",
             frames_sent, TRAIL_BYTES, bytes_taken, results_seen);
    $display("Row zero drained under a long output hold; closing frame was %s",
             finale.name());
    if (fail_count == 0 && results_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/sfu_pkg.sv
rtl/core/sysex_firmware_frame_unpacker.sv
test/sysex_firmware_frame_unpacker_tb.sv
